// ----- design/bmm_pkg.sv -----
// ----------------------------------------------------------------------------
// bmm_pkg: shared types and constants
// Item kinds, register indexes, sequencer states and binary32 constants for
// the batched matrix multiply block.
// ----------------------------------------------------------------------------
package bmm_pkg;

   localparam logic [31:0] FP_POS_ZERO  = 32'h0000_0000;
   localparam logic [31:0] FP_CANON_NAN = 32'h7FC0_0000;
   localparam logic [7:0]  FP_EXP_MAX   = 8'hFF;

   localparam logic [1:0] CSR_INNER_SIZE  = 2'd0;
   localparam logic [1:0] CSR_COL_COUNT   = 2'd1;
   localparam logic [1:0] CSR_ROW_COUNT   = 2'd2;
   localparam logic [1:0] CSR_BATCH_COUNT = 2'd3;

   typedef enum logic {
      KIND_LOAD = 1'b0,
      KIND_LEFT = 1'b1
   } item_kind_type;

   // Control part of one queued item.
   typedef struct packed {
      item_kind_type kind;
      logic          row_end;
      logic          end_batch;
      logic          end_all;
   } item_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_READ,
      ST_MUL,
      ST_NORM,
      ST_ROUND,
      ST_ALIGN,
      ST_ADD,
      ST_NEXT,
      ST_EMIT
   } mac_state_type;

endpackage

// ----- design/bmm_queue.sv -----
// ----------------------------------------------------------------------------
// bmm_queue: two-entry item queue
// Decouples the classifying front end from the arithmetic back end.
// ----------------------------------------------------------------------------
module bmm_queue #(
   parameter int WIDTH = 40
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             empty
);
   logic [WIDTH-1:0] slot_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

// ----- design/bmm_front.sv -----
// ----------------------------------------------------------------------------
// bmm_front: configuration and item classification
// Holds the size registers, tracks stream position and tags each beat as a
// right-matrix load or a left element with its row and batch markers.
// ----------------------------------------------------------------------------
module bmm_front #(
   parameter int MAX_INNER = 16,
   parameter int MAX_COLS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_valid,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [31:0]           req_tdata,
   output logic                  push,
   output bmm_pkg::item_ctl_type push_ctl,
   output logic [((MAX_INNER*MAX_COLS > 1) ? $clog2(MAX_INNER*MAX_COLS) : 1)-1:0] push_addr,
   output logic [31:0]           push_value,
   output logic [$clog2(MAX_COLS+1)-1:0] col_size
);
   import bmm_pkg::*;

   localparam int DEPTH  = MAX_INNER * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int KN_W   = $clog2(DEPTH + 1);
   localparam int K_W    = $clog2(MAX_INNER + 1);
   localparam int C_W    = $clog2(MAX_COLS + 1);

   logic [K_W-1:0]    k_ff, k_in;
   logic [C_W-1:0]    n_ff, n_in;
   logic [15:0]       m_ff, m_in;
   logic [15:0]       b_ff, b_in;
   logic [ADDR_W-1:0] load_pos_ff, load_pos_in;
   logic              left_phase_ff, left_phase_in;
   logic [K_W-1:0]    inner_pos_ff, inner_pos_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [15:0]       row_pos_ff, row_pos_in;
   logic [15:0]       batch_pos_ff, batch_pos_in;
   logic [KN_W-1:0]   kn;
   logic              accept;
   logic              load_done;
   logic              row_end;
   logic              end_batch;
   logic              end_all;

   assign accept   = req_tvalid & req_tready;
   assign col_size = n_ff;
   assign kn       = KN_W'(KN_W'(k_ff) * KN_W'(n_ff));

   always_comb begin
      load_done = ((KN_W'(load_pos_ff) + KN_W'(1)) >= kn);
      row_end   = ((inner_pos_ff + K_W'(1)) >= k_ff);
      end_batch = row_end && ((17'(row_pos_ff) + 17'd1) >= 17'(m_ff));
      end_all   = end_batch && ((17'(batch_pos_ff) + 17'd1) >= 17'(b_ff));
   end

   // Size registers, clamped on the way in.
   always_comb begin
      k_in = k_ff;
      n_in = n_ff;
      m_in = m_ff;
      b_in = b_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_INNER_SIZE: begin
               if (csr_data[4:0] == 5'd0) k_in = K_W'(1);
               else if (int'(csr_data[4:0]) > MAX_INNER) k_in = K_W'(MAX_INNER);
               else k_in = K_W'(csr_data[4:0]);
            end
            CSR_COL_COUNT: begin
               if (csr_data[4:0] == 5'd0) n_in = C_W'(1);
               else if (int'(csr_data[4:0]) > MAX_COLS) n_in = C_W'(MAX_COLS);
               else n_in = C_W'(csr_data[4:0]);
            end
            CSR_ROW_COUNT: begin
               m_in = (csr_data == 16'd0) ? 16'd1 : csr_data;
            end
            CSR_BATCH_COUNT: begin
               b_in = (csr_data == 16'd0) ? 16'd1 : csr_data;
            end
            default: begin
               k_in = k_ff;
            end
         endcase
      end
   end

   always_comb begin
      load_pos_in   = load_pos_ff;
      left_phase_in = left_phase_ff;
      inner_pos_in  = inner_pos_ff;
      base_in       = base_ff;
      row_pos_in    = row_pos_ff;
      batch_pos_in  = batch_pos_ff;
      if (csr_valid) begin
         load_pos_in   = '0;
         left_phase_in = 1'b0;
         inner_pos_in  = '0;
         base_in       = '0;
         row_pos_in    = '0;
         batch_pos_in  = '0;
      end else if (accept) begin
         if (!left_phase_ff) begin
            if (load_done) begin
               load_pos_in   = '0;
               left_phase_in = 1'b1;
            end else begin
               load_pos_in = load_pos_ff + ADDR_W'(1);
            end
         end else if (!row_end) begin
            inner_pos_in = inner_pos_ff + K_W'(1);
            base_in      = ADDR_W'(base_ff + ADDR_W'(n_ff));
         end else begin
            inner_pos_in = '0;
            base_in      = '0;
            if (end_batch) begin
               row_pos_in    = '0;
               left_phase_in = 1'b0;
               batch_pos_in  = end_all ? 16'd0 : batch_pos_ff + 16'd1;
            end else begin
               row_pos_in = row_pos_ff + 16'd1;
            end
         end
      end
   end

   always_comb begin
      push                = accept;
      push_value          = req_tdata;
      push_ctl.kind       = left_phase_ff ? KIND_LEFT : KIND_LOAD;
      push_ctl.row_end    = left_phase_ff & row_end;
      push_ctl.end_batch  = left_phase_ff & end_batch;
      push_ctl.end_all    = left_phase_ff & end_all;
      push_addr           = left_phase_ff ? base_ff : load_pos_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff          <= K_W'(1);
         n_ff          <= C_W'(1);
         m_ff          <= 16'd1;
         b_ff          <= 16'd1;
         load_pos_ff   <= '0;
         left_phase_ff <= 1'b0;
         inner_pos_ff  <= '0;
         base_ff       <= '0;
         row_pos_ff    <= '0;
         batch_pos_ff  <= '0;
      end else begin
         k_ff          <= k_in;
         n_ff          <= n_in;
         m_ff          <= m_in;
         b_ff          <= b_in;
         load_pos_ff   <= load_pos_in;
         left_phase_ff <= left_phase_in;
         inner_pos_ff  <= inner_pos_in;
         base_ff       <= base_in;
         row_pos_ff    <= row_pos_in;
         batch_pos_ff  <= batch_pos_in;
      end
   end
endmodule

// ----- design/bmm_mac.sv -----
// ----------------------------------------------------------------------------
// bmm_mac: right-matrix store and multiply-accumulate sequencer
// Writes loads into the store; for each left element walks the columns
// through one shared binary32 multiplier and adder, and emits a row after its last element.
// ----------------------------------------------------------------------------
module bmm_mac #(
   parameter int MAX_INNER = 16,
   parameter int MAX_COLS  = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  restart,
   input  logic [$clog2(MAX_COLS+1)-1:0] col_size,
   input  logic                  q_empty,
   input  bmm_pkg::item_ctl_type q_ctl,
   input  logic [((MAX_INNER*MAX_COLS > 1) ? $clog2(MAX_INNER*MAX_COLS) : 1)-1:0] q_addr,
   input  logic [31:0]           q_value,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [31:0]           rsp_tdata,
   output logic                  rsp_tlast,
   output logic [1:0]            rsp_tuser
);
   import bmm_pkg::*;

   localparam int DEPTH  = MAX_INNER * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int C_W    = $clog2(MAX_COLS + 1);
   localparam int CI_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

   mac_state_type state_ff, state_in;

   logic [31:0]        store_mem [DEPTH];
   logic [31:0]        rd_ff;
   logic [31:0]        acc_ff [MAX_COLS];
   logic [31:0]        x_ff;
   logic [ADDR_W-1:0]  base_ff;
   item_ctl_type       ctl_ff;
   logic [CI_W-1:0]    j_ff;
   logic [31:0]        prod_ff;
   logic               rnd_add_ff;
   logic               w_sign_ff;
   logic signed [9:0]  w_exp_ff;
   logic [47:0]        w_mant_ff;
   logic               w_stk_ff;
   logic [47:0]        big_ff;
   logic [47:0]        small_ff;
   logic               sub_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_data_ff;
   logic               rsp_last_ff;
   logic [1:0]         rsp_user_ff;

   logic [31:0]        acc_rd;
   logic               col_last;
   logic               out_free;
   logic               mem_we;
   logic               emit_load;
   logic [ADDR_W-1:0]  rd_addr;

   // Multiply operands.
   logic [7:0]  ma_e, mb_e, ma_ee, mb_ee;
   logic [23:0] ma_m, mb_m;
   logic        ma_nan, mb_nan, ma_inf, mb_inf, ma_zero, mb_zero;
   logic        mul_sign, mul_special;
   logic [31:0] mul_special_bits;
   logic [47:0] mul_mant;
   logic signed [9:0] mul_exp;

   // Add operands.
   logic        aa_nan, ab_nan, aa_inf, ab_inf, aa_zero, ab_zero;
   logic        add_special;
   logic [31:0] add_special_bits;
   logic        a_big;
   logic [31:0] big_v, small_v;
   logic [7:0]  big_e, small_e, shift_d;
   logic [71:0] small_sh;
   logic        align_stk;
   logic [48:0] diff;
   logic [47:0] sum_mant;
   logic        sum_stk;
   logic        add_zero;

   // Normalise and round.
   logic        norm_shl, norm_flush, norm_shr, norm_done;
   logic [24:0] rnd_sum;
   logic        rnd_up;
   logic [23:0] rnd_mant;
   logic signed [9:0] rnd_exp;
   logic [31:0] rnd_bits;

   assign acc_rd    = acc_ff[j_ff];
   assign col_last  = ((C_W'(j_ff) + C_W'(1)) == col_size);
   assign out_free  = !rsp_valid_ff || rsp_tready;
   assign rd_addr   = ADDR_W'(base_ff + ADDR_W'(j_ff));
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Multiplier front: classify, then one 24x24 product.
   always_comb begin
      ma_e    = x_ff[30:23];
      mb_e    = rd_ff[30:23];
      ma_ee   = (ma_e == 8'd0) ? 8'd1 : ma_e;
      mb_ee   = (mb_e == 8'd0) ? 8'd1 : mb_e;
      ma_m    = {(ma_e != 8'd0), x_ff[22:0]};
      mb_m    = {(mb_e != 8'd0), rd_ff[22:0]};
      ma_nan  = (ma_e == FP_EXP_MAX) && (x_ff[22:0] != 23'd0);
      mb_nan  = (mb_e == FP_EXP_MAX) && (rd_ff[22:0] != 23'd0);
      ma_inf  = (ma_e == FP_EXP_MAX) && (x_ff[22:0] == 23'd0);
      mb_inf  = (mb_e == FP_EXP_MAX) && (rd_ff[22:0] == 23'd0);
      ma_zero = (x_ff[30:0] == 31'd0);
      mb_zero = (rd_ff[30:0] == 31'd0);
      mul_sign = x_ff[31] ^ rd_ff[31];
      mul_special = 1'b1;
      if (ma_nan || mb_nan || (ma_inf && mb_zero) || (mb_inf && ma_zero)) begin
         mul_special_bits = FP_CANON_NAN;
      end else if (ma_inf || mb_inf) begin
         mul_special_bits = {mul_sign, FP_EXP_MAX, 23'd0};
      end else if (ma_zero || mb_zero) begin
         mul_special_bits = {mul_sign, 31'd0};
      end else begin
         mul_special_bits = FP_POS_ZERO;
         mul_special      = 1'b0;
      end
      mul_mant = ma_m * mb_m;
      mul_exp  = $signed({2'b00, ma_ee}) + $signed({2'b00, mb_ee}) - 10'sd126;
   end

   // Adder front: accumulator plus rounded product, aligned to the larger.
   always_comb begin
      aa_nan  = (acc_rd[30:23] == FP_EXP_MAX) && (acc_rd[22:0] != 23'd0);
      ab_nan  = (prod_ff[30:23] == FP_EXP_MAX) && (prod_ff[22:0] != 23'd0);
      aa_inf  = (acc_rd[30:23] == FP_EXP_MAX) && (acc_rd[22:0] == 23'd0);
      ab_inf  = (prod_ff[30:23] == FP_EXP_MAX) && (prod_ff[22:0] == 23'd0);
      aa_zero = (acc_rd[30:0] == 31'd0);
      ab_zero = (prod_ff[30:0] == 31'd0);
      add_special = 1'b1;
      if (aa_nan || ab_nan || (aa_inf && ab_inf && (acc_rd[31] != prod_ff[31]))) begin
         add_special_bits = FP_CANON_NAN;
      end else if (aa_inf) begin
         add_special_bits = acc_rd;
      end else if (ab_inf) begin
         add_special_bits = prod_ff;
      end else if (aa_zero && ab_zero) begin
         add_special_bits = {acc_rd[31] & prod_ff[31], 31'd0};
      end else if (aa_zero) begin
         add_special_bits = prod_ff;
      end else if (ab_zero) begin
         add_special_bits = acc_rd;
      end else begin
         add_special_bits = FP_POS_ZERO;
         add_special      = 1'b0;
      end
      a_big   = (acc_rd[30:0] >= prod_ff[30:0]);
      big_v   = a_big ? acc_rd : prod_ff;
      small_v = a_big ? prod_ff : acc_rd;
      big_e   = (big_v[30:23] == 8'd0) ? 8'd1 : big_v[30:23];
      small_e = (small_v[30:23] == 8'd0) ? 8'd1 : small_v[30:23];
      shift_d = big_e - small_e;
      small_sh  = {1'b0, (small_v[30:23] != 8'd0), small_v[22:0], 47'd0} >> shift_d;
      // Bits below the kept part of the wide word land in sticky, as does a shift of its whole width or more.
      align_stk = (shift_d >= 8'd72) || (small_sh[23:0] != 24'd0);
   end

   always_comb begin
      diff     = {big_ff, 1'b0} - {small_ff, w_stk_ff};
      sum_mant = sub_ff ? diff[48:1] : (big_ff + small_ff);
      sum_stk  = sub_ff ? diff[0] : w_stk_ff;
      add_zero = sub_ff && (diff == 49'd0);
   end

   // One normalising step per cycle; subnormal results shift right.
   always_comb begin
      norm_shl   = !w_mant_ff[47] && (w_exp_ff > 10'sd1) && (w_mant_ff != 48'd0);
      norm_flush = !norm_shl && (w_exp_ff < -10'sd48);
      norm_shr   = !norm_shl && !norm_flush && (w_exp_ff < 10'sd1);
      norm_done  = !norm_shl && !norm_flush && !norm_shr;
   end

   always_comb begin
      rnd_up  = w_mant_ff[23] && ((w_mant_ff[22:0] != 23'd0) || w_stk_ff || w_mant_ff[24]);
      rnd_sum = {1'b0, w_mant_ff[47:24]} + {24'd0, rnd_up};
      rnd_mant = rnd_sum[24] ? rnd_sum[24:1] : rnd_sum[23:0];
      rnd_exp  = rnd_sum[24] ? (w_exp_ff + 10'sd1) : w_exp_ff;
      if (rnd_exp >= 10'sd255) begin
         rnd_bits = {w_sign_ff, FP_EXP_MAX, 23'd0};
      end else begin
         rnd_bits = {w_sign_ff, (rnd_mant[23] ? rnd_exp[7:0] : 8'd0), rnd_mant[22:0]};
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (!q_empty && (q_ctl.kind == KIND_LEFT)) state_in = ST_READ;
         ST_READ:  state_in = ST_MUL;
         ST_MUL:   state_in = mul_special ? ST_ALIGN : ST_NORM;
         ST_NORM:  if (norm_done) state_in = ST_ROUND;
         ST_ROUND: state_in = rnd_add_ff ? ST_NEXT : ST_ALIGN;
         ST_ALIGN: state_in = add_special ? ST_NEXT : ST_ADD;
         ST_ADD:   state_in = add_zero ? ST_NEXT : ST_NORM;
         ST_NEXT: begin
            if (!col_last) state_in = ST_READ;
            else if (ctl_ff.row_end) state_in = ST_EMIT;
            else state_in = ST_IDLE;
         end
         ST_EMIT:  if (out_free && col_last) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop     = (state_ff == ST_IDLE) && !q_empty;
      mem_we    = q_pop && (q_ctl.kind == KIND_LOAD);
      emit_load = (state_ff == ST_EMIT) && out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[q_addr] <= q_value;
      end
      rd_ff <= store_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int i = 0; i < MAX_COLS; i++) begin
            acc_ff[i] <= FP_POS_ZERO;
         end
      end else begin
         case (state_ff)
            ST_ROUND: if (rnd_add_ff) acc_ff[j_ff] <= rnd_bits;
            ST_ALIGN: if (add_special) acc_ff[j_ff] <= add_special_bits;
            ST_ADD:   if (add_zero) acc_ff[j_ff] <= FP_POS_ZERO;
            ST_EMIT:  if (out_free) acc_ff[j_ff] <= FP_POS_ZERO;
            default:  acc_ff[j_ff] <= acc_ff[j_ff];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         j_ff <= '0;
      end else begin
         case (state_ff)
            ST_IDLE: j_ff <= '0;
            ST_NEXT: j_ff <= col_last ? '0 : j_ff + CI_W'(1);
            ST_EMIT: if (out_free && !col_last) j_ff <= j_ff + CI_W'(1);
            default: j_ff <= j_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            x_ff    <= q_value;
            base_ff <= q_addr;
            ctl_ff  <= q_ctl;
         end
         ST_MUL: begin
            prod_ff    <= mul_special_bits;
            rnd_add_ff <= 1'b0;
            w_sign_ff  <= mul_sign;
            w_exp_ff   <= mul_exp;
            w_mant_ff  <= mul_mant;
            w_stk_ff   <= 1'b0;
         end
         ST_NORM: begin
            if (norm_shl) begin
               w_mant_ff <= {w_mant_ff[46:0], 1'b0};
               w_exp_ff  <= w_exp_ff - 10'sd1;
            end else if (norm_flush) begin
               w_mant_ff <= 48'd0;
               w_stk_ff  <= w_stk_ff | (w_mant_ff != 48'd0);
               w_exp_ff  <= 10'sd1;
            end else if (norm_shr) begin
               w_mant_ff <= {1'b0, w_mant_ff[47:1]};
               w_stk_ff  <= w_stk_ff | w_mant_ff[0];
               w_exp_ff  <= w_exp_ff + 10'sd1;
            end
         end
         ST_ROUND: begin
            if (!rnd_add_ff) prod_ff <= rnd_bits;
         end
         ST_ALIGN: begin
            big_ff     <= {1'b0, (big_v[30:23] != 8'd0), big_v[22:0], 23'd0};
            small_ff   <= small_sh[71:24];
            w_stk_ff   <= align_stk;
            sub_ff     <= acc_rd[31] ^ prod_ff[31];
            w_sign_ff  <= big_v[31];
            w_exp_ff   <= $signed({2'b00, big_e}) + 10'sd1;
            rnd_add_ff <= 1'b1;
         end
         ST_ADD: begin
            w_mant_ff <= sum_mant;
            w_stk_ff  <= sum_stk;
         end
         default: begin
            x_ff <= x_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         if ((acc_rd[30:23] == FP_EXP_MAX) && (acc_rd[22:0] != 23'd0)) begin
            rsp_data_ff <= FP_CANON_NAN;
         end else begin
            rsp_data_ff <= acc_rd;
         end
         rsp_last_ff <= col_last;
         rsp_user_ff <= {col_last & ctl_ff.end_all, col_last & ctl_ff.end_batch};
      end
   end
endmodule

// ----- design/batched_matrix_multiply_fp32.sv -----
// ----------------------------------------------------------------------------
// batched_matrix_multiply_fp32: batched binary32 matrix product
// Streams right then left matrices in and row results out, C = A x B.
// ----------------------------------------------------------------------------
// Usage: write the four size registers over the csr_ channel while idle; any
// write restarts the stream at batch 0 and clears the row accumulators. For
// each batch send K*N right-matrix beats (row-major), then M*K left beats.
// A right beat is written to the store as it leaves the queue. A left beat
// leaves the queue and runs through one shared multiplier and adder once
// per column: read, multiply, normalise, round, align, add, normalise,
// round. Normalising shifts one bit per step, also for subnormal and
// cancellation results. The next beat is taken only once the sequencer is
// idle again. After the K-th beat of a row the N results leave one per cycle
// on rsp_ while rsp_tready is high, tlast marking the last column. A two-entry
// queue lets req_ accept while the back end works.
// When the receiver stalls the output register holds and the sequencer waits
// in its emit phase; the queue then fills and req_tready drops. Reset clears
// all sizes to one, all positions to zero and the accumulators to +0.0.
// ----------------------------------------------------------------------------
module batched_matrix_multiply_fp32 #(
   parameter int MAX_INNER = 16,
   parameter int MAX_COLS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // element_value
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // result_value
   output logic        rsp_tlast,   // last_of_row
   output logic [1:0]  rsp_tuser,   // [1] last_of_all, [0] last_of_batch
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);
   import bmm_pkg::*;

   localparam int DEPTH  = MAX_INNER * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int C_W    = $clog2(MAX_COLS + 1);
   localparam int Q_W    = $bits(item_ctl_type) + ADDR_W + 32;

   logic              push;
   item_ctl_type      push_ctl;
   logic [ADDR_W-1:0] push_addr;
   logic [31:0]       push_value;
   logic [C_W-1:0]    col_size;
   logic              q_full;
   logic              q_empty;
   logic              q_pop;
   logic [Q_W-1:0]    q_data;
   item_ctl_type      q_ctl;
   logic [ADDR_W-1:0] q_addr;
   logic [31:0]       q_value;

   assign csr_ready  = 1'b1;
   assign req_tready = !q_full;
   assign {q_ctl, q_addr, q_value} = q_data;

   bmm_front #(
      .MAX_INNER (MAX_INNER),
      .MAX_COLS  (MAX_COLS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_ctl   (push_ctl),
      .push_addr  (push_addr),
      .push_value (push_value),
      .col_size   (col_size)
   );

   bmm_queue #(
      .WIDTH (Q_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_ctl, push_addr, push_value}),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty)
   );

   bmm_mac #(
      .MAX_INNER (MAX_INNER),
      .MAX_COLS  (MAX_COLS)
   ) u_mac (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_valid),
      .col_size   (col_size),
      .q_empty    (q_empty),
      .q_ctl      (q_ctl),
      .q_addr     (q_addr),
      .q_value    (q_value),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );
endmodule
